@@ hdl/itp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the infix to postfix tokenizer.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int CH_W    = 8;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;

    localparam logic [2:0] PREC_ADD_SUB = 3'd4;
    localparam logic [2:0] PREC_MUL_DIV = 3'd5;

    typedef enum logic [1:0] {
        TK_OPERAND  = 2'd0,
        TK_OPERATOR = 2'd1,
        TK_ERROR    = 2'd2,
        TK_END      = 2'd3
    } t_token_kind;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op_code;

    typedef enum logic [2:0] {
        CC_OPEN,
        CC_CLOSE,
        CC_OPER,
        CC_OPERAND,
        CC_SPACE,
        CC_NUL,
        CC_ILLEGAL
    } t_char_class;

    typedef enum logic [2:0] {
        BS_DECODE,
        BS_READ,
        BS_EVAL,
        BS_PUSH,
        BS_LAST,
        BS_END,
        BS_FLUSH
    } t_back_state;

    typedef enum logic [1:0] {
        PM_CLOSE,
        PM_OPER,
        PM_DRAIN_NUL,
        PM_DRAIN_END
    } t_pop_mode;

    typedef struct packed {
        t_char_class cls;
        t_op_code    op;
        logic        last;
    } t_cmd_hdr;

    typedef struct packed {
        t_token_kind          kind;
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     length;
        t_op_code             op;
        logic                 last;
    } t_token;

    function automatic logic [2:0] op_prec(input t_op_code op);
        logic [2:0] prec;
        unique case (op)
            OP_ADD, OP_SUB: prec = PREC_ADD_SUB;
            OP_MUL, OP_DIV: prec = PREC_MUL_DIV;
            default:        prec = PREC_ADD_SUB;
        endcase
        return prec;
    endfunction

endpackage
`default_nettype wire

@@ hdl/itp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_in_if / itp_out_if
// Valid/ready channels for expression characters and postfix tokens.
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic                      valid;
    logic                      ready;
    logic [itp_pkg::CH_W-1:0]  ch;
    logic                      last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface itp_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   token_kind;
    logic [itp_pkg::START_W-1:0]  token_start;
    logic [itp_pkg::LEN_W-1:0]    token_length;
    logic [1:0]                   op_code;
    logic                         last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output op_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input op_code, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

@@ hdl/itp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_front
// Accepts characters, classifies them and tags each with its position.
// ----------------------------------------------------------------------------
module itp_front #(
    parameter int MAX_EXPR_LEN = 4096,
    parameter int POS_W        = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    itp_in_if.sink                  i_in,
    output itp_pkg::t_cmd_hdr       o_hdr,
    output logic [POS_W-1:0]        o_pos,
    output logic                    o_cmd_valid,
    input  wire logic               i_cmd_ready
);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_DIG_LO  = 8'h30;
    localparam logic [7:0] CH_DIG_HI  = 8'h39;
    localparam logic [7:0] CH_UP_LO   = 8'h41;
    localparam logic [7:0] CH_UP_HI   = 8'h5a;
    localparam logic [7:0] CH_LOW_LO  = 8'h61;
    localparam logic [7:0] CH_LOW_HI  = 8'h7a;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_EXPR_LEN - 1);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             w_accept;

    assign i_in.ready  = i_cmd_ready;
    assign o_cmd_valid = i_in.valid;
    assign w_accept    = i_in.valid && i_cmd_ready;
    assign o_pos       = r_pos;

    always_comb begin
        o_hdr.op   = itp_pkg::OP_ADD;
        o_hdr.last = i_in.last;
        unique case (i_in.ch) inside
            CH_OPEN:  o_hdr.cls = itp_pkg::CC_OPEN;
            CH_CLOSE: o_hdr.cls = itp_pkg::CC_CLOSE;
            CH_PLUS: begin
                o_hdr.cls = itp_pkg::CC_OPER;
                o_hdr.op  = itp_pkg::OP_ADD;
            end
            CH_MINUS: begin
                o_hdr.cls = itp_pkg::CC_OPER;
                o_hdr.op  = itp_pkg::OP_SUB;
            end
            CH_STAR: begin
                o_hdr.cls = itp_pkg::CC_OPER;
                o_hdr.op  = itp_pkg::OP_MUL;
            end
            CH_SLASH: begin
                o_hdr.cls = itp_pkg::CC_OPER;
                o_hdr.op  = itp_pkg::OP_DIV;
            end
            CH_SPACE, CH_TAB: o_hdr.cls = itp_pkg::CC_SPACE;
            CH_NUL:           o_hdr.cls = itp_pkg::CC_NUL;
            [CH_DIG_LO:CH_DIG_HI], CH_DOT, [CH_UP_LO:CH_UP_HI], [CH_LOW_LO:CH_LOW_HI]:
                o_hdr.cls = itp_pkg::CC_OPERAND;
            default:          o_hdr.cls = itp_pkg::CC_ILLEGAL;
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (i_in.last) begin
                n_pos = '0;
            end else if (r_pos < POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

@@ hdl/itp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module itp_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/itp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_back
// Operand tracking, operator stack and token output of the tokenizer.
// ----------------------------------------------------------------------------
module itp_back #(
    parameter int STACK_DEPTH = 16,
    parameter int POS_W       = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_ready,
    input  wire itp_pkg::t_cmd_hdr  i_hdr,
    input  wire logic [POS_W-1:0]   i_pos,
    itp_out_if.source               o_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = (POS_W + 1 > itp_pkg::LEN_W) ? POS_W + 1 : itp_pkg::LEN_W;
    localparam int SW = (POS_W > itp_pkg::START_W) ? POS_W : itp_pkg::START_W;

    typedef struct packed {
        logic               is_paren;
        itp_pkg::t_op_code  op;
        logic [POS_W-1:0]   pos;
    } t_entry;

    function automatic logic [itp_pkg::START_W-1:0] to_start(input logic [POS_W-1:0] p);
        logic [SW-1:0] wide;
        wide = SW'(p);
        return wide[itp_pkg::START_W-1:0];
    endfunction

    function automatic itp_pkg::t_token make_tok(
        input itp_pkg::t_token_kind   kind,
        input logic [POS_W-1:0]       p,
        input logic [LW-1:0]          len,
        input itp_pkg::t_op_code      op
    );
        itp_pkg::t_token tok;
        tok.kind   = kind;
        tok.start  = to_start(p);
        tok.length = len[itp_pkg::LEN_W-1:0];
        tok.op     = op;
        tok.last   = 1'b0;
        return tok;
    endfunction

    t_entry                 r_stack [STACK_DEPTH];
    t_entry                 r_rd_data;

    itp_pkg::t_back_state   r_state;
    itp_pkg::t_back_state   n_state;
    itp_pkg::t_pop_mode     r_mode;
    itp_pkg::t_pop_mode     n_mode;
    itp_pkg::t_cmd_hdr      r_hdr;
    itp_pkg::t_cmd_hdr      n_hdr;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic [POS_W-1:0]       r_start;
    logic [POS_W-1:0]       n_start;
    logic                   r_in_op;
    logic                   n_in_op;
    logic                   r_err;
    logic                   n_err;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic                   n_out_valid;
    itp_pkg::t_token        r_out;
    itp_pkg::t_token        n_out;
    logic                   r_pend_valid;
    logic                   n_pend_valid;
    itp_pkg::t_token        r_pend;
    itp_pkg::t_token        n_pend;

    logic                   w_out_free;
    logic                   w_can_emit;
    logic                   w_need_emit;
    logic                   w_need_flush;
    logic                   w_hold;
    logic                   w_emit;
    logic                   w_flush;
    itp_pkg::t_token        w_tok;
    logic                   w_term;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_pop_oper;
    logic                   w_push;
    logic [CW-1:0]          w_top_idx;
    logic [AW-1:0]          w_rd_addr;
    logic [AW-1:0]          w_wr_addr;
    t_entry                 w_wr_entry;
    logic [LW-1:0]          w_len_cut;
    logic [LW-1:0]          w_len_end;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_can_emit = !r_pend_valid || w_out_free;
    assign w_term     = (i_hdr.cls == itp_pkg::CC_CLOSE) || (i_hdr.cls == itp_pkg::CC_SPACE)
                     || (i_hdr.cls == itp_pkg::CC_NUL);
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_pop_oper = !r_rd_data.is_paren
                     && (itp_pkg::op_prec(r_rd_data.op) >= itp_pkg::op_prec(r_hdr.op));
    assign w_top_idx  = r_count - 1'b1;
    assign w_rd_addr  = w_top_idx[AW-1:0];
    assign w_wr_addr  = r_count[AW-1:0];
    assign w_len_cut  = LW'(i_pos) - LW'(r_start);
    assign w_len_end  = LW'(r_pos) - LW'(r_start) + LW'(1);

    assign w_wr_entry.is_paren = (r_hdr.cls == itp_pkg::CC_OPEN);
    assign w_wr_entry.op       = r_hdr.op;
    assign w_wr_entry.pos      = r_pos;
    assign w_push              = (r_state == itp_pkg::BS_PUSH) && !w_hold && !w_full;

    // work out whether this cycle emits a token or closes a run
    always_comb begin
        w_need_emit  = 1'b0;
        w_need_flush = 1'b0;
        w_tok        = make_tok(itp_pkg::TK_END, r_pos, '0, itp_pkg::OP_ADD);
        unique case (r_state)
            itp_pkg::BS_DECODE: begin
                w_need_emit = i_cmd_valid && !r_err
                           && ((r_in_op && w_term)
                               || (!r_in_op && i_hdr.cls == itp_pkg::CC_ILLEGAL));
                if (r_in_op) begin
                    w_tok = make_tok(itp_pkg::TK_OPERAND, r_start, w_len_cut, itp_pkg::OP_ADD);
                end else begin
                    w_tok = make_tok(itp_pkg::TK_ERROR, i_pos, LW'(1), itp_pkg::OP_ADD);
                end
            end
            itp_pkg::BS_EVAL: begin
                if (r_mode == itp_pkg::PM_OPER) begin
                    w_need_emit = w_pop_oper;
                end else begin
                    w_need_emit = !r_rd_data.is_paren;
                end
                w_tok = make_tok(itp_pkg::TK_OPERATOR, r_rd_data.pos, LW'(1), r_rd_data.op);
            end
            itp_pkg::BS_PUSH: begin
                w_need_emit = w_full;
                w_tok       = make_tok(itp_pkg::TK_ERROR, r_pos, LW'(1), itp_pkg::OP_ADD);
            end
            itp_pkg::BS_LAST: begin
                w_need_emit  = r_hdr.last && !r_err && r_in_op;
                w_need_flush = !r_hdr.last;
                w_tok        = make_tok(itp_pkg::TK_OPERAND, r_start, w_len_end,
                                        itp_pkg::OP_ADD);
            end
            itp_pkg::BS_END: begin
                w_need_emit = 1'b1;
            end
            itp_pkg::BS_FLUSH: begin
                w_need_flush = 1'b1;
            end
            default: begin
                w_need_emit  = 1'b0;
            end
        endcase
        w_hold  = (w_need_emit && !w_can_emit) || (w_need_flush && r_pend_valid && !w_out_free);
        w_emit  = w_need_emit && !w_hold;
        w_flush = w_need_flush && !w_hold;
    end

    assign o_cmd_ready = (r_state == itp_pkg::BS_DECODE) && !w_hold;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itp_pkg::BS_DECODE: begin
                if (i_cmd_valid && !w_hold) begin
                    if (r_err || (r_in_op && !w_term)) begin
                        n_state = itp_pkg::BS_LAST;
                    end else begin
                        unique case (i_hdr.cls)
                            itp_pkg::CC_OPEN:  n_state = itp_pkg::BS_PUSH;
                            itp_pkg::CC_CLOSE,
                            itp_pkg::CC_OPER,
                            itp_pkg::CC_NUL:   n_state = itp_pkg::BS_READ;
                            default:           n_state = itp_pkg::BS_LAST;
                        endcase
                    end
                end
            end
            itp_pkg::BS_READ: begin
                if (w_empty) begin
                    unique case (r_mode)
                        itp_pkg::PM_OPER:      n_state = itp_pkg::BS_PUSH;
                        itp_pkg::PM_DRAIN_END: n_state = itp_pkg::BS_END;
                        default:               n_state = itp_pkg::BS_LAST;
                    endcase
                end else begin
                    n_state = itp_pkg::BS_EVAL;
                end
            end
            itp_pkg::BS_EVAL: begin
                if (!w_hold) begin
                    unique case (r_mode)
                        itp_pkg::PM_CLOSE:
                            n_state = r_rd_data.is_paren ? itp_pkg::BS_LAST : itp_pkg::BS_READ;
                        itp_pkg::PM_OPER:
                            n_state = w_pop_oper ? itp_pkg::BS_READ : itp_pkg::BS_PUSH;
                        default:
                            n_state = itp_pkg::BS_READ;
                    endcase
                end
            end
            itp_pkg::BS_PUSH: begin
                if (!w_hold) begin
                    n_state = itp_pkg::BS_LAST;
                end
            end
            itp_pkg::BS_LAST: begin
                if (!w_hold) begin
                    if (!r_hdr.last) begin
                        n_state = itp_pkg::BS_DECODE;
                    end else if (r_err) begin
                        n_state = itp_pkg::BS_END;
                    end else begin
                        n_state = itp_pkg::BS_READ;
                    end
                end
            end
            itp_pkg::BS_END: begin
                if (!w_hold) begin
                    n_state = itp_pkg::BS_FLUSH;
                end
            end
            itp_pkg::BS_FLUSH: begin
                if (!w_hold) begin
                    n_state = itp_pkg::BS_DECODE;
                end
            end
            default: n_state = itp_pkg::BS_DECODE;
        endcase
    end

    // expression state, stack count and token registers
    always_comb begin
        n_mode       = r_mode;
        n_hdr        = r_hdr;
        n_pos        = r_pos;
        n_start      = r_start;
        n_in_op      = r_in_op;
        n_err        = r_err;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;

        unique case (r_state)
            itp_pkg::BS_DECODE: begin
                if (i_cmd_valid && !w_hold) begin
                    n_hdr = i_hdr;
                    n_pos = i_pos;
                    if (!r_err && (!r_in_op || w_term)) begin
                        n_in_op = 1'b0;
                        unique case (i_hdr.cls)
                            itp_pkg::CC_OPERAND: begin
                                n_in_op = 1'b1;
                                n_start = i_pos;
                            end
                            itp_pkg::CC_ILLEGAL: n_err  = 1'b1;
                            itp_pkg::CC_CLOSE:   n_mode = itp_pkg::PM_CLOSE;
                            itp_pkg::CC_OPER:    n_mode = itp_pkg::PM_OPER;
                            itp_pkg::CC_NUL:     n_mode = itp_pkg::PM_DRAIN_NUL;
                            default:             n_mode = r_mode;
                        endcase
                    end
                end
            end
            itp_pkg::BS_READ: begin
                if (w_empty && r_mode == itp_pkg::PM_DRAIN_NUL) begin
                    n_err = 1'b1;
                end
            end
            itp_pkg::BS_EVAL: begin
                if (!w_hold && (r_mode != itp_pkg::PM_OPER || w_pop_oper)) begin
                    n_count = r_count - 1'b1;
                end
            end
            itp_pkg::BS_PUSH: begin
                if (!w_hold) begin
                    if (w_full) begin
                        n_err = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            itp_pkg::BS_LAST: begin
                if (!w_hold && r_hdr.last && !r_err) begin
                    n_in_op = 1'b0;
                    n_mode  = itp_pkg::PM_DRAIN_END;
                end
            end
            itp_pkg::BS_END: begin
                if (!w_hold) begin
                    n_in_op = 1'b0;
                    n_start = '0;
                    n_count = '0;
                    n_err   = 1'b0;
                end
            end
            default: n_count = r_count;
        endcase

        // hold one token back so the final token of a run can be marked
        if (w_emit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_pend;
            end
            n_pend_valid = 1'b1;
            n_pend       = w_tok;
        end else if (w_flush && r_pend_valid) begin
            n_out_valid  = 1'b1;
            n_out        = r_pend;
            n_out.last   = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[w_wr_addr] <= w_wr_entry;
        end
        if (r_state == itp_pkg::BS_READ) begin
            r_rd_data <= r_stack[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= itp_pkg::BS_DECODE;
            r_mode       <= itp_pkg::PM_CLOSE;
            r_start      <= '0;
            r_in_op      <= 1'b0;
            r_err        <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_start      <= n_start;
            r_in_op      <= n_in_op;
            r_err        <= n_err;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr  <= n_hdr;
        r_pos  <= n_pos;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.token_kind   = r_out.kind;
    assign o_out.token_start  = r_out.start;
    assign o_out.token_length = r_out.length;
    assign o_out.op_code      = r_out.op;
    assign o_out.last_of_run  = r_out.last;

endmodule
`default_nettype wire

@@ hdl/infix_to_postfix_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_tokenizer
// Streaming shunting-yard converter from infix characters to postfix tokens.
//
// i_in takes one ASCII character per word, last marking the end of an
// expression. o_out gives tokens (operand, operator, error, end) as start
// position and length; last_of_run marks the final token caused by a word.
// The front tags each character with its position and classifies it, then
// a two-entry queue hands it to the back, which owns the operator stack.
// In the back a character passes through decode and wrap-up, and a push adds
// its own state. Each stack entry popped or dropped adds a memory read, then a
// compare and emit; an operator stopped by a lower entry adds a read and a
// compare, a walk that finds the stack empty adds a read, and the end of an
// expression adds an end and a flush state. Tokens pass through a one-deep
// hold register and the output register; a held token moves on when the back
// makes its next token or closes the run. When the receiver stalls, the back
// waits with its tokens and the queue keeps taking characters until full.
// Reset clears the position, the stack count and all handshake state;
// the stack memory needs no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_tokenizer #(
    parameter int STACK_DEPTH  = 16,
    parameter int MAX_EXPR_LEN = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itp_in_if.sink      i_in,
    itp_out_if.source   o_out
);

    localparam int POS_W = $clog2(MAX_EXPR_LEN);
    localparam int HDR_W = $bits(itp_pkg::t_cmd_hdr);
    localparam int CMD_W = HDR_W + POS_W;

    itp_pkg::t_cmd_hdr  w_front_hdr;
    logic [POS_W-1:0]   w_front_pos;
    logic               w_front_valid;
    logic               w_front_ready;
    logic [CMD_W-1:0]   w_fifo_in;
    logic [CMD_W-1:0]   w_fifo_out;
    logic               w_back_valid;
    logic               w_back_ready;
    itp_pkg::t_cmd_hdr  w_back_hdr;
    logic [POS_W-1:0]   w_back_pos;

    itp_front #(
        .MAX_EXPR_LEN (MAX_EXPR_LEN),
        .POS_W        (POS_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_hdr        (w_front_hdr),
        .o_pos        (w_front_pos),
        .o_cmd_valid  (w_front_valid),
        .i_cmd_ready  (w_front_ready)
    );

    assign w_fifo_in  = {w_front_hdr, w_front_pos};

    itp_fifo #(
        .WIDTH   (CMD_W),
        .DEPTH   (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_data  (w_fifo_in),
        .o_valid (w_back_valid),
        .i_ready (w_back_ready),
        .o_data  (w_fifo_out)
    );

    assign w_back_hdr = itp_pkg::t_cmd_hdr'(w_fifo_out[CMD_W-1:POS_W]);
    assign w_back_pos = w_fifo_out[POS_W-1:0];

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .POS_W       (POS_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_back_valid),
        .o_cmd_ready (w_back_ready),
        .i_hdr       (w_back_hdr),
        .i_pos       (w_back_pos),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the infix to postfix tokenizer.
//
// Characters go in on one valid/ready channel and postfix tokens come back on
// another. A shunting-yard predictor in the bench mirrors the position, the
// operand tracking and the operator stack, and queues the tokens each accepted
// character must produce. A monitor compares every token taken from the block
// against the oldest queued one. Directed tests hit precedence, parentheses,
// illegal and NUL characters and stack overflow; a random phase then sends
// mostly well-formed expressions, plus broken ones and raw byte noise, with
// random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH   = 16;
    localparam int MAX_POS = 4095;
    localparam int N_ITEMS = 250;

    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = ".";

    localparam logic [2:0] ENT_OPEN = 3'd4;

    logic i_clk;
    logic i_rst_n;

    itp_in_if  chr_if ();
    itp_out_if tok_if ();

    infix_to_postfix_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chr_if),
        .o_out   (tok_if)
    );

    // predictor state
    int          cur_pos;
    bit          in_opd;
    int          opd_start;
    logic [2:0]  stk_kind [DEPTH];
    logic [11:0] stk_pos  [DEPTH];
    int          stk_cnt;
    bit          err_seen;

    itp_pkg::t_token tok_q [$];
    logic [7:0]      expr_q [$];

    bit idle_on;
    int stall_left;
    int stall_pick;
    int n_fail;
    int n_mismatch;
    int n_chars;
    int n_tokens;
    int n_err_tok;
    int n_end_tok;

    itp_pkg::t_token got;
    itp_pkg::t_token want;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_state();
        cur_pos   = 0;
        in_opd    = 1'b0;
        opd_start = 0;
        stk_cnt   = 0;
        err_seen  = 1'b0;
    endfunction

    function automatic void emit_tok(input itp_pkg::t_token_kind kind, input int start,
                                     input int len, input itp_pkg::t_op_code op);
        itp_pkg::t_token t;
        t.kind   = kind;
        t.start  = start[itp_pkg::START_W-1:0];
        t.length = len[itp_pkg::LEN_W-1:0];
        t.op     = op;
        t.last   = 1'b0;
        tok_q.push_back(t);
    endfunction

    function automatic logic [2:0] entry_rank(input logic [2:0] kind);
        logic [2:0] rank;
        if (kind == ENT_OPEN) begin
            rank = 3'd0;
        end else if (kind == {1'b0, itp_pkg::OP_MUL} || kind == {1'b0, itp_pkg::OP_DIV}) begin
            rank = itp_pkg::PREC_MUL_DIV;
        end else begin
            rank = itp_pkg::PREC_ADD_SUB;
        end
        return rank;
    endfunction

    function automatic void emit_pop(input int idx);
        emit_tok(itp_pkg::TK_OPERATOR, int'(stk_pos[idx]), 1,
                 itp_pkg::t_op_code'(stk_kind[idx][1:0]));
    endfunction

    function automatic void push_entry(input logic [2:0] kind, input int p);
        if (stk_cnt >= DEPTH) begin
            err_seen = 1'b1;
            emit_tok(itp_pkg::TK_ERROR, p, 1, itp_pkg::OP_ADD);
        end else begin
            stk_kind[stk_cnt] = kind;
            stk_pos[stk_cnt]  = p[11:0];
            stk_cnt++;
        end
    endfunction

    function automatic void drain_stack();
        while (stk_cnt > 0) begin
            stk_cnt--;
            if (stk_kind[stk_cnt] != ENT_OPEN) emit_pop(stk_cnt);
        end
    endfunction

    function automatic bit oper_of(input logic [7:0] ch, output itp_pkg::t_op_code op);
        bit hit;
        hit = 1'b1;
        op  = itp_pkg::OP_ADD;
        if (ch == CH_PLUS) op = itp_pkg::OP_ADD;
        else if (ch == CH_MINUS) op = itp_pkg::OP_SUB;
        else if (ch == CH_STAR) op = itp_pkg::OP_MUL;
        else if (ch == CH_SLASH) op = itp_pkg::OP_DIV;
        else hit = 1'b0;
        return hit;
    endfunction

    function automatic bit is_operand_ch(input logic [7:0] ch);
        return (ch >= "0" && ch <= "9") || ch == CH_DOT ||
               (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    // Queue the tokens one character causes.
    function automatic void predict_tokens(input logic [7:0] ch, input bit last);
        int                n0;
        int                p;
        bit                is_op;
        itp_pkg::t_op_code op;
        itp_pkg::t_token   t;
        n0    = tok_q.size();
        p     = cur_pos;
        is_op = oper_of(ch, op);
        if (!err_seen) begin
            if (in_opd && (ch == CH_CLOSE || ch == CH_SPACE || ch == CH_TAB ||
                           ch == CH_NUL)) begin
                emit_tok(itp_pkg::TK_OPERAND, opd_start, p - opd_start, itp_pkg::OP_ADD);
                in_opd = 1'b0;
            end
            if (!in_opd) begin
                if (ch == CH_OPEN) begin
                    push_entry(ENT_OPEN, p);
                end else if (ch == CH_CLOSE) begin
                    while (stk_cnt > 0) begin
                        stk_cnt--;
                        if (stk_kind[stk_cnt] == ENT_OPEN) break;
                        emit_pop(stk_cnt);
                    end
                end else if (is_op) begin
                    while (stk_cnt > 0 &&
                           entry_rank(stk_kind[stk_cnt-1]) >= entry_rank({1'b0, op})) begin
                        stk_cnt--;
                        emit_pop(stk_cnt);
                    end
                    push_entry({1'b0, op}, p);
                end else if (is_operand_ch(ch)) begin
                    in_opd    = 1'b1;
                    opd_start = p;
                end else if (ch == CH_SPACE || ch == CH_TAB) begin
                end else if (ch == CH_NUL) begin
                    drain_stack();
                    err_seen = 1'b1;
                end else begin
                    emit_tok(itp_pkg::TK_ERROR, p, 1, itp_pkg::OP_ADD);
                    err_seen = 1'b1;
                end
            end
        end
        if (last) begin
            if (!err_seen) begin
                if (in_opd) begin
                    emit_tok(itp_pkg::TK_OPERAND, opd_start, p + 1 - opd_start,
                             itp_pkg::OP_ADD);
                end
                drain_stack();
            end
            emit_tok(itp_pkg::TK_END, p, 0, itp_pkg::OP_ADD);
            clear_state();
        end else if (cur_pos < MAX_POS) begin
            cur_pos++;
        end
        if (tok_q.size() > n0) begin
            t = tok_q.pop_back();
            t.last = 1'b1;
            tok_q.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_char(input logic [7:0] ch, input bit last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            chr_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        chr_if.valid <= 1'b1;
        chr_if.ch    <= ch;
        chr_if.last  <= last;
        @(posedge i_clk);
        while (!chr_if.ready) @(posedge i_clk);
        n_chars++;
        predict_tokens(ch, last);
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], close && (i == s.len() - 1));
        end
    endtask

    // send expr_q as one expression
    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++) begin
            send_char(expr_q[i], i == expr_q.size() - 1);
        end
        expr_q.delete();
    endtask

    function automatic void put_sep();
        int n;
        n = ($urandom_range(0, 4) == 0) ? 2 : 1;
        repeat (n) expr_q.push_back(($urandom_range(0, 5) == 0) ? CH_TAB : CH_SPACE);
    endfunction

    function automatic logic [7:0] rand_operand_ch();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'($urandom_range("0", "9"));
        if (r < 7) return 8'($urandom_range("a", "z"));
        if (r < 9) return 8'($urandom_range("A", "Z"));
        return CH_DOT;
    endfunction

    function automatic logic [7:0] rand_oper_ch();
        unique case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic void build_wellformed();
        int depth;
        int terms;
        int len;
        depth = 0;
        terms = $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0) put_sep();
        for (int i = 0; i < terms; i++) begin
            if (i > 0) begin
                // skip the separator now and then so the operator joins the operand
                if ($urandom_range(0, 19) != 0) put_sep();
                expr_q.push_back(rand_oper_ch());
                if ($urandom_range(0, 1) == 0) put_sep();
            end
            while (depth < 7 && $urandom_range(0, 2) == 0) begin
                expr_q.push_back(CH_OPEN);
                depth++;
                if ($urandom_range(0, 2) == 0) put_sep();
            end
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
            repeat (len) expr_q.push_back(rand_operand_ch());
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 3) == 0) put_sep();
                expr_q.push_back(CH_CLOSE);
                depth--;
            end
        end
        while (depth > 0) begin
            expr_q.push_back(CH_CLOSE);
            depth--;
        end
        if ($urandom_range(0, 4) == 0) put_sep();
    endfunction

    function automatic void build_broken();
        int idx;
        build_wellformed();
        idx = $urandom_range(0, expr_q.size() - 1);
        unique case ($urandom_range(0, 2))
            0: expr_q[idx] = 8'($urandom_range(0, 255));
            1: expr_q.insert(idx, CH_CLOSE);
            default: expr_q.insert(idx, CH_OPEN);
        endcase
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_precedence();
        send_text("a * (b - c) / d + e", 1'b1);
        send_text("x1\t-\t(y.2+z)", 1'b1);
    endtask

    task automatic test_special_chars();
        send_text("x $ y", 1'b1);
        send_text("+ )", 1'b1);
        send_text("(7", 1'b1);
        send_char("q", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char("w", 1'b0);
        send_char(CH_PLUS, 1'b1);
        send_char(8'hff, 1'b1);
    endtask

    task automatic test_overflow();
        repeat (DEPTH) send_char(CH_OPEN, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char("z", 1'b1);
        repeat (DEPTH + 1) send_char(CH_OPEN, 1'b0);
        send_char(CH_SPACE, 1'b1);
    endtask

    task automatic test_random_expressions();
        int r;
        while (n_chars < N_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) build_wellformed();
            else if (r < 85) build_broken();
            else build_noise();
            idle_on = ($urandom_range(0, 7) != 0);
            send_expr();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // output side: stall the receiver and check each token
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tok_if.ready <= 1'b0;
        end else if (!idle_on) begin
            tok_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            tok_if.ready <= 1'b0;
            stall_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 70) begin
                tok_if.ready <= 1'b1;
            end else if (stall_pick < 95) begin
                tok_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                tok_if.ready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            got.kind   = itp_pkg::t_token_kind'(tok_if.token_kind);
            got.start  = tok_if.token_start;
            got.length = tok_if.token_length;
            got.op     = itp_pkg::t_op_code'(tok_if.op_code);
            got.last   = tok_if.last_of_run;
            n_tokens++;
            if (got.kind == itp_pkg::TK_ERROR) n_err_tok++;
            if (got.kind == itp_pkg::TK_END) n_end_tok++;
            if (tok_q.size() == 0) begin
                n_fail++;
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("%0t: unexpected token kind=%0d start=%0d len=%0d op=%0d last=%0b",
                             $realtime, got.kind, got.start, got.length, got.op, got.last);
                end
            end else begin
                want = tok_q.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.length !== want.length || got.op !== want.op ||
                    got.last !== want.last) begin
                    n_fail++;
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("%0t: token mismatch exp kind=%0d start=%0d len=%0d op=%0d last=%0b",
                                 $realtime, want.kind, want.start, want.length, want.op,
                                 want.last);
                        $display("%0t:                got kind=%0d start=%0d len=%0d op=%0d last=%0b",
                                 $realtime, got.kind, got.start, got.length, got.op,
                                 got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        i_rst_n      = 1'b0;
        chr_if.valid = 1'b0;
        chr_if.ch    = '0;
        chr_if.last  = 1'b0;
        idle_on      = 1'b1;
        stall_left   = 0;
        n_fail       = 0;
        n_mismatch   = 0;
        n_chars      = 0;
        n_tokens     = 0;
        n_err_tok    = 0;
        n_end_tok    = 0;
        clear_state();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_precedence();
        test_special_chars();
        test_overflow();
        test_random_expressions();

        @(negedge i_clk);
        chr_if.valid <= 1'b0;
        waited = 0;
        while (tok_q.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (tok_q.size() > 0) begin
            n_fail += tok_q.size();
            $display("%0d expected tokens never arrived", tok_q.size());
        end

        $display("Sent %0d characters, checked %0d tokens (%0d error, %0d end).",
                 n_chars, n_tokens, n_err_tok, n_end_tok);
        $display("Covered precedence, parentheses, illegal/NUL input, overflow, stalls.");
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures", n_fail);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d tokens outstanding", tok_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
